@@ hdl/mcbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_pkg
// Types and constants of the multi-click button decoder.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int TIME_BITS = 32;
  localparam int QUIET_MS  = 500;

  localparam int DEBOUNCE_W = 16;
  localparam int MINUTES_W  = 8;
  localparam int MAIN_W     = 24;
  localparam int BREAK_W    = 19;
  localparam int REM_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAIN_W-1:0]     MAIN_LONG_MS   = MAIN_W'(600000);
  localparam logic [MAIN_W-1:0]     MAIN_RESET_MS  = MAIN_W'(300000);
  localparam logic [BREAK_W-1:0]    BREAK_SHORT_MS = BREAK_W'(120000);
  localparam logic [BREAK_W-1:0]    BREAK_LONG_MS  = BREAK_W'(300000);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
  localparam logic [15:0]           MS_PER_MIN     = 16'd60000;

  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 2^TIME_BITS
  localparam int RECIP_SHIFT = TIME_BITS + 10;
  localparam int RECIP_W     = TIME_BITS + 1;
  localparam logic [RECIP_SHIFT:0] RECIP_POW = {1'b1, {RECIP_SHIFT{1'b0}}};
  localparam logic [RECIP_SHIFT:0] RECIP_FULL = (RECIP_POW + (RECIP_SHIFT+1)'(999))
                                                / (RECIP_SHIFT+1)'(1000);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W = TIME_BITS + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH    = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RESTART = 3'd1,
    ACT_MAIN    = 3'd2,
    ACT_BREAK   = 3'd3,
    ACT_SHORT   = 3'd4
  } mcbd_action_e;

endpackage

@@ hdl/multi_click_button_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_click_button_decoder_top
// Debounced multi-click button decoder: counts presses and classifies them
// into restart, main toggle, break toggle and short break actions.
//
// Takes one sample per cycle while the output is not stalled and returns
// exactly one result per sample, in order. Each sample passes the input
// register, then the stage that forms the reciprocal product for the
// whole-second sync, then the stage that applies the press
// counting state and fills the result register. Configuration writes
// are always taken and must only be issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module multi_click_button_decoder_top
  import mcbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_BITS-1:0]  now_ms_i,
  input  logic                  pressed_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            action_o,
  output logic [TIME_BITS-1:0]  start_ms_o,
  output logic [MAIN_W-1:0]     main_len_ms_o,
  output logic [BREAK_W-1:0]    break_len_ms_o,
  output logic [MAIN_W-1:0]     confirm_value_ms_o,
  output logic                  confirm_is_break_o
);

  // configuration
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [MAIN_W-1:0]     cfg_main_q;
  logic [TIME_BITS-1:0]  epoch_q;
  logic [MAIN_W-1:0]     cfg_main_d;

  // stage a: input register
  logic                 a_valid_q;
  logic [TIME_BITS-1:0] a_now_q;
  logic                 a_pressed_q;

  // stage b: reciprocal product
  logic                 b_valid_q;
  logic [TIME_BITS-1:0] b_now_q;
  logic [TIME_BITS-1:0] b_diff_q;
  logic                 b_pressed_q;
  logic [PROD_W-1:0]    b_prod_q;

  // decoder state
  logic                 prev_level_q;
  logic [TIME_BITS-1:0] last_press_q;
  logic [7:0]           count_q;
  logic [MAIN_W-1:0]    main_len_q;
  logic [BREAK_W-1:0]   break_len_q;

  // result register
  logic                 out_valid_q;
  mcbd_action_e         action_q;
  logic [TIME_BITS-1:0] start_q;
  logic [MAIN_W-1:0]    main_out_q;
  logic [BREAK_W-1:0]   break_out_q;
  logic [MAIN_W-1:0]    confirm_q;
  logic                 is_break_q;

  logic                 out_move;
  logic                 b_move;
  logic                 a_move;
  logic                 in_take;

  logic [TIME_BITS-1:0] a_diff;
  logic [TIME_BITS-1:0] quot;
  logic [TIME_BITS-1:0] quot_x1000;
  logic [TIME_BITS-1:0] rem_full;
  logic [TIME_BITS-1:0] synced;
  logic [TIME_BITS-1:0] since;
  logic                 counted;
  logic                 fire;

  mcbd_action_e         action_d;
  logic [TIME_BITS-1:0] start_d;
  logic [MAIN_W-1:0]    main_len_d;
  logic [BREAK_W-1:0]   break_len_d;
  logic [MAIN_W-1:0]    confirm_d;
  logic                 is_break_d;
  logic [7:0]           count_d;
  logic [TIME_BITS-1:0] last_press_d;

  assign out_move   = !out_valid_q || out_ready_i;
  assign b_move     = b_valid_q && out_move;
  assign a_move     = a_valid_q && (!b_valid_q || out_move);
  assign in_take    = in_valid_i && in_ready_o;
  assign in_ready_o = !a_valid_q || !b_valid_q || out_move;
  assign cfg_ready_o = 1'b1;

  assign cfg_main_d = MAIN_W'(cfg_data_i[MINUTES_W-1:0]) * MAIN_W'(MS_PER_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      cfg_main_q <= MAIN_RESET_MS;
      epoch_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_MAIN_MIN: cfg_main_q <= cfg_main_d;
        CFG_EPOCH:    epoch_q    <= cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign a_diff = a_now_q - epoch_q;

  // x mod 1000 from the registered product; x * 1000 = x*1024 - x*16 - x*8
  assign quot       = TIME_BITS'(b_prod_q[PROD_W-1:RECIP_SHIFT]);
  assign quot_x1000 = (quot << 10) - (quot << 4) - (quot << 3);
  assign rem_full   = b_diff_q - quot_x1000;
  assign synced     = b_now_q - TIME_BITS'(rem_full[REM_W-1:0]);

  assign since   = b_now_q - last_press_q;
  assign counted = b_pressed_q && !prev_level_q && (since > TIME_BITS'(debounce_q));
  assign fire    = !b_pressed_q && (since > TIME_BITS'(QUIET_MS)) && (count_q != '0);

  always_comb begin
    action_d     = ACT_NONE;
    start_d      = '0;
    confirm_d    = '0;
    is_break_d   = 1'b0;
    main_len_d   = main_len_q;
    break_len_d  = break_len_q;
    count_d      = count_q;
    last_press_d = last_press_q;
    if (counted) begin
      last_press_d = b_now_q;
      if (count_q != 8'hff) begin
        count_d = count_q + 8'd1;
      end
    end
    if (fire) begin
      count_d = '0;
      unique case (count_q)
        8'd1: begin
          action_d = ACT_RESTART;
          start_d  = synced;
        end
        8'd2: begin
          action_d   = ACT_MAIN;
          main_len_d = (main_len_q == cfg_main_q) ? MAIN_LONG_MS : cfg_main_q;
          confirm_d  = main_len_d;
        end
        8'd3: begin
          action_d    = ACT_BREAK;
          break_len_d = (break_len_q == BREAK_SHORT_MS) ? BREAK_LONG_MS : BREAK_SHORT_MS;
          confirm_d   = MAIN_W'(break_len_d);
          is_break_d  = 1'b1;
        end
        8'd4: begin
          action_d = ACT_SHORT;
          start_d  = synced;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_level_q <= 1'b0;
      last_press_q <= '0;
      count_q      <= '0;
      main_len_q   <= MAIN_RESET_MS;
      break_len_q  <= BREAK_SHORT_MS;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (!b_valid_q || out_move) begin
        b_valid_q <= a_valid_q;
      end
      if (out_move) begin
        out_valid_q <= b_valid_q;
      end
      if (b_move) begin
        prev_level_q <= b_pressed_q;
        last_press_q <= last_press_d;
        count_q      <= count_d;
        main_len_q   <= main_len_d;
        break_len_q  <= break_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_now_q     <= now_ms_i;
      a_pressed_q <= pressed_i;
    end
    if (a_move) begin
      b_now_q     <= a_now_q;
      b_diff_q    <= a_diff;
      b_pressed_q <= a_pressed_q;
      b_prod_q    <= PROD_W'(a_diff) * PROD_W'(RECIP);
    end
    if (b_move) begin
      action_q    <= action_d;
      start_q     <= start_d;
      main_out_q  <= main_len_d;
      break_out_q <= break_len_d;
      confirm_q   <= confirm_d;
      is_break_q  <= is_break_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign action_o           = action_q;
  assign start_ms_o         = start_q;
  assign main_len_ms_o      = main_out_q;
  assign break_len_ms_o     = break_out_q;
  assign confirm_value_ms_o = confirm_q;
  assign confirm_is_break_o = is_break_q;

endmodule

@@ hdl/mcbd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_checker
// Port-level checks on the result stream of the multi-click button decoder.
// ----------------------------------------------------------------------------
module mcbd_checker
  import mcbd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [2:0]            action_o,
  input logic [TIME_BITS-1:0]  start_ms_o,
  input logic [BREAK_W-1:0]    break_len_ms_o,
  input logic [MAIN_W-1:0]     confirm_value_ms_o,
  input logic                  confirm_is_break_o
);

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_RESTART && action_o != ACT_SHORT |-> start_ms_o == '0)
    else $error("start time set for an action without sync");

  a_confirm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_MAIN && action_o != ACT_BREAK
      |-> confirm_value_ms_o == '0 && !confirm_is_break_o)
    else $error("confirmation set for an action without toggle");

  a_confirm_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_BREAK
      |-> confirm_is_break_o && MAIN_W'(break_len_ms_o) == confirm_value_ms_o)
    else $error("break confirmation does not match break length");

  a_break_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> break_len_ms_o == BREAK_SHORT_MS || break_len_ms_o == BREAK_LONG_MS)
    else $error("break length outside its two values");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) && $stable(start_ms_o))
    else $error("stalled result transaction changed");

endmodule

bind multi_click_button_decoder_top mcbd_checker u_mcbd_checker (.*);
